// ===== hdl/bmhq_pkg.sv =====
package bmhq_pkg;

    localparam int KEY_W            = 32;
    localparam int REQ_W            = 2;
    localparam int STATUS_W         = 2;
    localparam int FILL_W           = 7;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH    = 2'd0,
        REQ_POP     = 2'd1,
        REQ_REPLACE = 2'd2,
        REQ_PEEK    = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef logic signed [KEY_W-1:0] t_key;

endpackage

// ===== hdl/bmhq_if.sv =====
interface bmhq_req_if;
    logic              valid;
    logic              ready;
    bmhq_pkg::t_req    req_type;
    bmhq_pkg::t_key    key_in;

    modport source (output valid, output req_type, output key_in, input ready);
    modport sink   (input valid, input req_type, input key_in, output ready);
endinterface

interface bmhq_rsp_if;
    logic                          valid;
    logic                          ready;
    bmhq_pkg::t_key                key_out;
    bmhq_pkg::t_status             status;
    logic [bmhq_pkg::FILL_W-1:0]   fill_count;

    modport source (output valid, output key_out, output status, output fill_count,
                    input ready);
    modport sink   (input valid, input key_out, input status, input fill_count,
                    output ready);
endinterface

// ===== hdl/bmhq_store.sv =====
module bmhq_store #(
    parameter int DEPTH  = bmhq_pkg::DEFAULT_CAPACITY,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  bmhq_pkg::t_key       i_wr_data,
    input  logic [ADDR_W-1:0]    i_rd_addr_a,
    input  logic [ADDR_W-1:0]    i_rd_addr_b,
    output bmhq_pkg::t_key       o_rd_data_a,
    output bmhq_pkg::t_key       o_rd_data_b
);

    bmhq_pkg::t_key r_mem [DEPTH];
    bmhq_pkg::t_key r_rd_a;
    bmhq_pkg::t_key r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

// ===== hdl/binary_max_heap_queue_unit.sv =====
// Max-priority queue of signed Q16.16 keys held as a binary heap in one
// synchronous memory (one write port, two registered read ports).
// i_req carries one request: req_type (push, pop max, replace root, peek
// root) and key_in. o_rsp returns one response per request: key_out (root
// removed or peeked, 0 for push and errors), status (ok, empty, full) and
// fill_count (keys held afterwards, low 7 bits).
// Requests are handled one at a time; i_req.ready is high only while the
// sequencer is idle. Errors and a push onto an empty heap finish in the
// idle state at acceptance; peek passes through the root-read wait and
// root states. Each heap level takes a read wait state and a compare and
// write-back state; pop and replace first read the root the same way and
// also check the level they stop at. A new request is taken only once the
// finished response has moved into the output register.
// The response sits in an output register, so a stalled receiver does not
// stop the next request being accepted; the sequencer waits only if the
// register is still full when its next response is ready.
// Reset empties the heap at once (count to zero); memory contents are not
// cleared, and values at or beyond the count are never used.
module binary_max_heap_queue_unit #(
    parameter int CAPACITY = bmhq_pkg::DEFAULT_CAPACITY
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmhq_req_if.sink      i_req,
    bmhq_rsp_if.source    o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CHD_W = IDX_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROOT_W,
        S_ROOT,
        S_UP_W,
        S_UP,
        S_PLACE,
        S_DOWN_W,
        S_DOWN
    } t_state;

    t_state                r_state, n_state;
    logic                  r_done, n_done;
    bmhq_pkg::t_req        r_req, n_req;
    bmhq_pkg::t_key        r_key, n_key;
    bmhq_pkg::t_key        r_result, n_result;
    bmhq_pkg::t_status     r_status, n_status;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [IDX_W-1:0]      r_pos, n_pos;
    logic [IDX_W-1:0]      r_ra, n_ra;
    logic [IDX_W-1:0]      r_rb, n_rb;
    logic                  r_out_valid, n_out_valid;
    bmhq_pkg::t_key        r_key_out, n_key_out;
    bmhq_pkg::t_status     r_out_status, n_out_status;
    logic [CNT_W-1:0]      r_out_count, n_out_count;

    logic                  we;
    logic [IDX_W-1:0]      wr_addr;
    bmhq_pkg::t_key        wr_data;
    bmhq_pkg::t_key        rd_a;
    bmhq_pkg::t_key        rd_b;

    logic [IDX_W-1:0]      parent;
    logic [IDX_W-1:0]      grand;
    logic [CHD_W-1:0]      left, right, best_c;
    logic                  take_left, take_right;
    bmhq_pkg::t_key        cmp_key;
    logic                  out_free;
    logic                  accept;

    bmhq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_we        (we),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (wr_data),
        .i_rd_addr_a (r_ra),
        .i_rd_addr_b (r_rb),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign i_req.ready      = (r_state == S_IDLE) && !r_done;
    assign accept           = i_req.valid && i_req.ready;
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.key_out    = r_key_out;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.fill_count = bmhq_pkg::FILL_W'(r_out_count);
    assign out_free         = !r_out_valid || o_rsp.ready;

    assign parent     = (r_pos - IDX_W'(1)) >> 1;
    assign grand      = (parent - IDX_W'(1)) >> 1;
    assign left       = (CHD_W'(r_pos) << 1) + CHD_W'(1);
    assign right      = left + CHD_W'(1);
    assign take_left  = (left < CHD_W'(r_count)) && (rd_a > r_key);
    assign cmp_key    = take_left ? rd_a : r_key;
    assign take_right = (right < CHD_W'(r_count)) && (rd_b > cmp_key);
    assign best_c     = take_right ? right : left;

    always_comb begin
        n_state      = r_state;
        n_done       = r_done;
        n_req        = r_req;
        n_key        = r_key;
        n_result     = r_result;
        n_status     = r_status;
        n_count      = r_count;
        n_pos        = r_pos;
        n_ra         = r_ra;
        n_rb         = r_rb;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_key_out    = r_key_out;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        we           = 1'b0;
        wr_addr      = r_pos;
        wr_data      = r_key;

        case (r_state)
            S_IDLE: begin
                if (r_done) begin
                    if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_key_out    = r_result;
                        n_out_status = r_status;
                        n_out_count  = r_count;
                        n_done       = 1'b0;
                    end
                end else if (accept) begin
                    n_req    = i_req.req_type;
                    n_key    = i_req.key_in;
                    n_result = '0;
                    n_status = bmhq_pkg::ST_OK;
                    if (i_req.req_type == bmhq_pkg::REQ_PUSH) begin
                        if (r_count == CNT_W'(CAPACITY)) begin
                            n_status = bmhq_pkg::ST_FULL;
                            n_done   = 1'b1;
                        end else begin
                            n_count = r_count + CNT_W'(1);
                            n_pos   = IDX_W'(r_count);
                            if (r_count == '0) begin
                                we      = 1'b1;
                                wr_addr = '0;
                                wr_data = i_req.key_in;
                                n_done  = 1'b1;
                            end else begin
                                n_ra    = IDX_W'((r_count - CNT_W'(1)) >> 1);
                                n_state = S_UP_W;
                            end
                        end
                    end else if (r_count == '0) begin
                        n_status = bmhq_pkg::ST_EMPTY;
                        n_done   = 1'b1;
                    end else begin
                        n_ra    = '0;
                        n_rb    = IDX_W'(r_count - CNT_W'(1));
                        n_state = S_ROOT_W;
                    end
                end
            end
            S_ROOT_W: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                n_result = rd_a;
                n_pos    = '0;
                n_ra     = IDX_W'(1);
                n_rb     = IDX_W'(2);
                case (r_req)
                    bmhq_pkg::REQ_POP: begin
                        n_count = r_count - CNT_W'(1);
                        n_key   = rd_b;
                        if (r_count == CNT_W'(1)) begin
                            n_done  = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_state = S_DOWN_W;
                        end
                    end
                    bmhq_pkg::REQ_REPLACE: begin
                        n_state = S_DOWN_W;
                    end
                    default: begin
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_UP_W: begin
                n_state = S_UP;
            end
            S_UP: begin
                we = 1'b1;
                if (r_key > rd_a) begin
                    wr_data = rd_a;
                    n_pos   = parent;
                    if (parent == '0) begin
                        n_state = S_PLACE;
                    end else begin
                        n_ra    = grand;
                        n_state = S_UP_W;
                    end
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_PLACE: begin
                we      = 1'b1;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            S_DOWN_W: begin
                n_state = S_DOWN;
            end
            S_DOWN: begin
                we = 1'b1;
                if (take_left || take_right) begin
                    wr_data = take_right ? rd_b : rd_a;
                    n_pos   = IDX_W'(best_c);
                    n_ra    = IDX_W'((best_c << 1) + CHD_W'(1));
                    n_rb    = IDX_W'((best_c << 1) + CHD_W'(2));
                    n_state = S_DOWN_W;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_req        <= n_req;
        r_key        <= n_key;
        r_result     <= n_result;
        r_status     <= n_status;
        r_pos        <= n_pos;
        r_ra         <= n_ra;
        r_rb         <= n_rb;
        r_key_out    <= n_key_out;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("heap count beyond capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1) ||
             r_count == $past(r_count) - CNT_W'(1)))
        else $error("heap count moved by more than one");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !i_req.ready)
        else $error("request taken while previous one in progress");

    a_rsp_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_done && out_free) |=> o_rsp.valid)
        else $error("finished response not presented");

endmodule

// ===== verif/binary_max_heap_queue_unit_checker.sv =====
`timescale 1ns / 100ps

module binary_max_heap_queue_unit_checker #(
    parameter int CAPACITY = bmhq_pkg::DEFAULT_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmhq_req_if        i_req,
    bmhq_rsp_if        i_rsp,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_answered,
    output int         o_full_hits,
    output int         o_empty_hits
);

    typedef struct packed {
        bmhq_pkg::t_key               key;
        bmhq_pkg::t_status            status;
        logic [bmhq_pkg::FILL_W-1:0]  fill;
    } t_heap_answer;

    bmhq_pkg::t_key  heap_keys [CAPACITY];
    int unsigned     heap_len;
    t_heap_answer    answer_q [$];
    t_heap_answer    want;
    int              fails;
    int              answered;
    int              full_hits;
    int              empty_hits;

    task automatic sift_root_down();
        int unsigned    pos;
        int unsigned    lc;
        int unsigned    rc;
        int unsigned    best;
        bmhq_pkg::t_key tmp;
        bit             done;
        pos  = 0;
        done = 1'b0;
        while (!done) begin
            lc   = 2 * pos + 1;
            rc   = 2 * pos + 2;
            best = pos;
            if (lc < heap_len && heap_keys[lc] > heap_keys[best]) best = lc;
            if (rc < heap_len && heap_keys[rc] > heap_keys[best]) best = rc;
            if (best == pos) begin
                done = 1'b1;
            end else begin
                tmp             = heap_keys[pos];
                heap_keys[pos]  = heap_keys[best];
                heap_keys[best] = tmp;
                pos             = best;
            end
        end
    endtask

    task automatic apply_heap_request(input bmhq_pkg::t_req op, input bmhq_pkg::t_key key,
                                      output t_heap_answer ans);
        int unsigned    pos;
        int unsigned    parent;
        bmhq_pkg::t_key tmp;
        bit             done;
        ans.key    = '0;
        ans.status = bmhq_pkg::ST_OK;
        if (op == bmhq_pkg::REQ_PUSH) begin
            if (heap_len >= CAPACITY) begin
                ans.status = bmhq_pkg::ST_FULL;
            end else begin
                heap_keys[heap_len] = key;
                pos                 = heap_len;
                heap_len++;
                done = 1'b0;
                while (pos > 0 && !done) begin
                    parent = (pos - 1) / 2;
                    if (heap_keys[pos] > heap_keys[parent]) begin
                        tmp               = heap_keys[pos];
                        heap_keys[pos]    = heap_keys[parent];
                        heap_keys[parent] = tmp;
                        pos               = parent;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
        end else if (heap_len == 0) begin
            ans.status = bmhq_pkg::ST_EMPTY;
        end else begin
            ans.key = heap_keys[0];
            if (op == bmhq_pkg::REQ_POP) begin
                heap_len--;
                heap_keys[0] = heap_keys[heap_len];
                sift_root_down();
            end else if (op == bmhq_pkg::REQ_REPLACE) begin
                heap_keys[0] = key;
                sift_root_down();
            end
        end
        ans.fill = bmhq_pkg::FILL_W'(heap_len);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            answer_q.delete();
            heap_len   = 0;
            fails      = 0;
            answered   = 0;
            full_hits  = 0;
            empty_hits = 0;
        end else begin
            // response first: one accepted at the same edge belongs to an older request
            if (i_rsp.valid && i_rsp.ready) begin
                answered++;
                if (answer_q.size() == 0) begin
                    $error("response with no request outstanding: key_out %0d status %0d",
                           i_rsp.key_out, i_rsp.status);
                    fails++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_rsp.key_out !== want.key) begin
                        $error("key_out mismatch: expected %0d, got %0d",
                               want.key, i_rsp.key_out);
                        fails++;
                    end
                    if (i_rsp.status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, i_rsp.status);
                        fails++;
                    end
                    if (i_rsp.fill_count !== want.fill) begin
                        $error("fill_count mismatch: expected %0d, got %0d",
                               want.fill, i_rsp.fill_count);
                        fails++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                apply_heap_request(i_req.req_type, i_req.key_in, want);
                answer_q.push_back(want);
                if (want.status == bmhq_pkg::ST_FULL)  full_hits++;
                if (want.status == bmhq_pkg::ST_EMPTY) empty_hits++;
            end
        end
        o_fail_count <= fails;
        o_pending    <= answer_q.size();
        o_answered   <= answered;
        o_full_hits  <= full_hits;
        o_empty_hits <= empty_hits;
    end

endmodule

// ===== verif/binary_max_heap_queue_unit_tb.sv =====
`timescale 1ns / 100ps

module binary_max_heap_queue_unit_tb;

    localparam int CAPACITY     = bmhq_pkg::DEFAULT_CAPACITY;
    localparam int RANDOM_ITEMS = 750;
    localparam int PHASE_ITEMS  = RANDOM_ITEMS / 3;
    localparam int TAIL_CYCLES  = 40;

    logic clk;
    logic rst_n;

    bmhq_req_if req_ch ();
    bmhq_rsp_if rsp_ch ();

    int fail_count;
    int pending;
    int answered;
    int full_hits;
    int empty_hits;

    int src_idle_pct;
    int sink_idle_pct;
    int hold_token;
    int hold_seen;
    int hold_left;
    int hold_len;
    int level;
    int sent;

    binary_max_heap_queue_unit #(
        .CAPACITY (CAPACITY)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    binary_max_heap_queue_unit_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_answered   (answered),
        .o_full_hits  (full_hits),
        .o_empty_hits (empty_hits)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random stalls, plus a long hold-off whenever the token moves
    initial begin
        rsp_ch.ready <= 1'b0;
        hold_seen    <= 0;
        hold_left    <= 0;
        forever begin
            @(posedge clk);
            if (!rst_n) begin
                rsp_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left    <= hold_left - 1;
            end else if (hold_seen != hold_token) begin
                hold_seen    <= hold_token;
                hold_left    <= hold_len;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    function automatic bmhq_pkg::t_key pick_key();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2, 3:    return bmhq_pkg::t_key'(int'($urandom_range(0, 6)) - 3);
            4:       return bmhq_pkg::t_key'({$urandom_range(0, 7), 16'h0000});
            default: return bmhq_pkg::t_key'($urandom());
        endcase
    endfunction

    task automatic send_request(input bmhq_pkg::t_req op, input bmhq_pkg::t_key key);
        while ($urandom_range(99) < src_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= op;
        req_ch.key_in   <= key;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if (op == bmhq_pkg::REQ_PUSH && level < CAPACITY) level++;
        if (op == bmhq_pkg::REQ_POP && level > 0) level--;
        sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int             phase_start;
        bmhq_pkg::t_req op;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.req_type <= bmhq_pkg::REQ_PUSH;
        req_ch.key_in   <= '0;
        src_idle_pct     = 0;
        sink_idle_pct   <= 0;
        hold_token      <= 0;
        hold_len        <= 0;
        level            = 0;
        sent             = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty-heap errors, extreme keys, ties, every request kind
        send_request(bmhq_pkg::REQ_POP, '0);
        send_request(bmhq_pkg::REQ_REPLACE, 32'sd5);
        send_request(bmhq_pkg::REQ_PEEK, '0);
        send_request(bmhq_pkg::REQ_PUSH, 32'sd0);
        send_request(bmhq_pkg::REQ_PUSH, 32'sh7FFF_FFFF);
        send_request(bmhq_pkg::REQ_PUSH, 32'sh8000_0000);
        send_request(bmhq_pkg::REQ_PUSH, -32'sd1);
        send_request(bmhq_pkg::REQ_PUSH, 32'sh0001_0000);
        send_request(bmhq_pkg::REQ_PUSH, 32'sh0001_0000);
        send_request(bmhq_pkg::REQ_PUSH, 32'sd1);
        send_request(bmhq_pkg::REQ_PEEK, 32'sh1234_5678);
        send_request(bmhq_pkg::REQ_REPLACE, 32'sh8000_0000);
        send_request(bmhq_pkg::REQ_POP, '0);
        send_request(bmhq_pkg::REQ_REPLACE, 32'sh7FFF_FFFF);
        send_request(bmhq_pkg::REQ_REPLACE, 32'sh7FFF_FFFF);
        while (level > 0) send_request(bmhq_pkg::REQ_POP, '0);
        send_request(bmhq_pkg::REQ_POP, '0);
        wait_drained();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct   = 12;
                    sink_idle_pct <= 52;
                end
                1: begin
                    src_idle_pct   = 52;
                    sink_idle_pct <= 12;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_idle_pct <= 0;
                end
            endcase
            phase_start = sent;
            if (phase == 0) begin
                // long receiver hold-off while the heap is filled to the brim
                hold_len   <= 150;
                hold_token <= hold_token + 1;
                while (level < CAPACITY) send_request(bmhq_pkg::REQ_PUSH, pick_key());
                repeat (2) send_request(bmhq_pkg::REQ_PUSH, pick_key());
            end
            while (sent - phase_start < PHASE_ITEMS) begin
                case ($urandom_range(0, 2))
                    0: begin
                        while (level < CAPACITY) begin
                            op = ($urandom_range(99) < 80)
                                 ? bmhq_pkg::REQ_PUSH
                                 : bmhq_pkg::t_req'($urandom_range(1, 3));
                            send_request(op, pick_key());
                        end
                        repeat ($urandom_range(1, 3))
                            send_request(bmhq_pkg::REQ_PUSH, pick_key());
                    end
                    1: begin
                        while (level > 0) begin
                            op = ($urandom_range(99) < 75)
                                 ? bmhq_pkg::REQ_POP
                                 : bmhq_pkg::t_req'($urandom_range(0, 3));
                            send_request(op, pick_key());
                        end
                        repeat ($urandom_range(1, 3))
                            send_request(bmhq_pkg::t_req'($urandom_range(1, 3)), pick_key());
                    end
                    default: begin
                        repeat ($urandom_range(20, 40))
                            send_request(bmhq_pkg::t_req'($urandom_range(0, 3)), pick_key());
                    end
                endcase
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run summary: %0d requests, %0d responses checked, %0d full and %0d empty",
                 sent, answered, full_hits, empty_hits);
        $display("Covered fill-to-full and drain-to-empty runs, ties, extreme keys, stalls");
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== binary_max_heap_queue_unit.f =====
hdl/bmhq_pkg.sv
hdl/bmhq_if.sv
hdl/bmhq_store.sv
hdl/binary_max_heap_queue_unit.sv
verif/binary_max_heap_queue_unit_checker.sv
verif/binary_max_heap_queue_unit_tb.sv
